// ===== rtl/core/cft_pkg.sv =====
// Shared types, codes and character constants for the CSV field tokenizer.
// Depends on nothing; every other file of the block imports it.
package cft_pkg;

   // Counter widths of the tokenizer.
   localparam int ROW_BITS  = 24;
   localparam int COL_BITS  = 10;
   localparam int LEN_BITS  = 16;
   localparam int BYTE_BITS = 8;

   localparam logic [COL_BITS-1:0] COL_MAX = {COL_BITS{1'b1}};

   // Characters with a special meaning in CSV text.
   localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_BITS-1:0] CH_COMMA = 8'h2C;

   // Input beat kinds.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOF  = 1'b1;

   // Parser states; the two unused codes behave as the error state.
   typedef enum logic [2:0] {
      ST_START  = 3'd0,
      ST_QUOTED = 3'd1,
      ST_QQUOTE = 3'd2,
      ST_PLAIN  = 3'd3,
      ST_CR     = 3'd4,
      ST_ERROR  = 3'd5
   } parse_state_type;

   // Result event codes.
   typedef enum logic [1:0] {
      EV_CHAR  = 2'd0,
      EV_FIELD = 2'd1,
      EV_ROW   = 2'd2,
      EV_ERR   = 2'd3
   } event_type;

   // Error codes carried with an error event.
   typedef enum logic [1:0] {
      ERR_LONG = 2'd0,
      ERR_CR   = 2'd1,
      ERR_EOF  = 2'd2
   } err_code_type;

   // What one input beat does to the parser.
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_CHAR  = 3'd1,
      ACT_FIELD = 3'd2,
      ACT_ROW   = 3'd3,
      ACT_ERR   = 3'd4
   } action_type;

   // One result beat.
   typedef struct packed {
      event_type             evt;
      logic [BYTE_BITS-1:0]  out_byte;
      logic [ROW_BITS-1:0]   row_index;
      logic [COL_BITS-1:0]   col_index;
      logic [LEN_BITS-1:0]   field_len;
      err_code_type          error_code;
   } rsp_type;

endpackage

// ===== rtl/core/cft_parse_fsm.sv =====
// Parser state machine with row, column and field length counters.
// Turns one accepted input beat into at most one result beat; uses cft_pkg.
module cft_parse_fsm (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            in_kind,
   input  logic [cft_pkg::BYTE_BITS-1:0]   in_byte,
   input  logic [cft_pkg::LEN_BITS-1:0]    max_field_len,
   output logic                            has_result,
   output cft_pkg::rsp_type                result
);
   import cft_pkg::*;

   parse_state_type        state_ff, state_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   action_type             act;
   err_code_type           err_code;
   parse_state_type        char_next;
   logic                   overflow;

   // A character is refused once the field already holds the limit.
   assign overflow = (len_ff >= max_field_len);

   // Next state and the action the beat takes.
   always_comb begin
      state_in  = state_ff;
      act       = ACT_NONE;
      err_code  = ERR_LONG;
      char_next = ST_PLAIN;
      if (in_kind == KIND_EOF) begin
         case (state_ff)
            ST_PLAIN, ST_QQUOTE: begin
               act = ACT_FIELD;
            end
            ST_QUOTED, ST_CR: begin
               act      = ACT_ERR;
               err_code = ERR_EOF;
            end
            default: begin
               act = ACT_NONE;
            end
         endcase
      end else begin
         case (state_ff)
            ST_START, ST_QQUOTE, ST_PLAIN: begin
               if (in_byte == CH_CR) begin
                  state_in = ST_CR;
               end else if (in_byte == CH_LF) begin
                  act = ACT_ROW;
               end else if (in_byte == CH_COMMA) begin
                  act = ACT_FIELD;
               end else if (in_byte == CH_QUOTE) begin
                  // A doubled quote yields one quote; a stray one opens quoting.
                  if (state_ff == ST_QQUOTE) begin
                     act       = ACT_CHAR;
                     char_next = ST_QUOTED;
                  end else begin
                     state_in = ST_QUOTED;
                  end
               end else begin
                  act = ACT_CHAR;
               end
            end
            ST_QUOTED: begin
               if (in_byte == CH_QUOTE) begin
                  state_in = ST_QQUOTE;
               end else begin
                  act       = ACT_CHAR;
                  char_next = ST_QUOTED;
               end
            end
            ST_CR: begin
               if (in_byte == CH_LF) begin
                  act = ACT_ROW;
               end else begin
                  act      = ACT_ERR;
                  err_code = ERR_CR;
               end
            end
            default: begin
               act = ACT_NONE;
            end
         endcase
      end

      // Field ends return to start; errors are sticky.
      case (act)
         ACT_CHAR: begin
            if (overflow) begin
               act      = ACT_ERR;
               err_code = ERR_LONG;
               state_in = ST_ERROR;
            end else begin
               state_in = char_next;
            end
         end
         ACT_FIELD, ACT_ROW: begin
            state_in = ST_START;
         end
         ACT_ERR: begin
            state_in = ST_ERROR;
         end
         default: begin
         end
      endcase
   end

   // Result beat and counter updates.
   always_comb begin
      has_result        = 1'b1;
      result.evt        = EV_CHAR;
      result.out_byte   = '0;
      result.row_index  = row_ff;
      result.col_index  = col_ff;
      result.field_len  = '0;
      result.error_code = ERR_LONG;
      row_in            = row_ff;
      col_in            = col_ff;
      len_in            = len_ff;
      case (act)
         ACT_CHAR: begin
            result.out_byte = in_byte;
            len_in          = len_ff + LEN_BITS'(1);
         end
         ACT_FIELD: begin
            result.evt       = EV_FIELD;
            result.field_len = len_ff;
            len_in           = '0;
            if (col_ff != COL_MAX) begin
               col_in = col_ff + COL_BITS'(1);
            end
         end
         ACT_ROW: begin
            result.evt       = EV_ROW;
            result.field_len = len_ff;
            len_in           = '0;
            col_in           = '0;
            row_in           = row_ff + ROW_BITS'(1);
         end
         ACT_ERR: begin
            result.evt        = EV_ERR;
            result.error_code = err_code;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   // State and counters advance on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         row_ff   <= '0;
         col_ff   <= '0;
         len_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         len_ff   <= len_in;
      end
   end

   // An error result leaves the parser in the error state.
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && has_result && result.evt == EV_ERR |=> state_ff == ST_ERROR)
      else $error("error result did not enter the error state");

   // Nothing is produced once in the error state.
   a_err_silent: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff == ST_ERROR |-> !has_result)
      else $error("result produced in the error state");

   // A row end restarts the column count.
   a_row_clears_col: assert property (@(posedge clock) disable iff (reset)
      accept && has_result && result.evt == EV_ROW |=> col_ff == '0 && len_ff == '0)
      else $error("row end did not clear column and length");

endmodule

// ===== rtl/core/cft_out_reg.sv =====
// Result register between the parser and the result channel.
// Holds one result beat until the consumer takes it; uses cft_pkg.
module cft_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  cft_pkg::rsp_type   load_data,
   input  logic               out_stall,
   output logic               out_valid,
   output cft_pkg::rsp_type   out_data,
   output logic               can_load
);
   import cft_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // The register may be refilled when empty or when its beat leaves now.
   assign can_load = !valid_ff || !out_stall;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      if (can_load && load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // A load while the held beat is stalled would lose that beat.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && out_stall |=> valid_ff && $stable(data_ff))
      else $error("held result was overwritten");

endmodule

// ===== rtl/core/csv_field_tokenizer_top.sv =====
// Top level of the CSV field tokenizer: configuration register and channels.
// Instantiates cft_parse_fsm and cft_out_reg; uses cft_pkg.
//
//   Channel   Dir  Handshake               Payload
//   req_      in   req_valid / req_stall   kind, data_byte
//   rsp_      out  rsp_valid / rsp_stall   event, byte, row, col, length, error
//   csr_      in   csr_valid / csr_ready   max_field_len
//
// One input beat is accepted per cycle while req_stall is low; its result, if any,
// appears in the next cycle. The parser state is one register stage.
// Reset is synchronous and returns the parser to start and max_field_len to 4095.
// req_stall rises only while a result is held and rsp_stall is high.
module csv_field_tokenizer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [cft_pkg::BYTE_BITS-1:0]  req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_event_res,
   output logic [cft_pkg::BYTE_BITS-1:0]  rsp_out_byte,
   output logic [cft_pkg::ROW_BITS-1:0]   rsp_row_index,
   output logic [cft_pkg::COL_BITS-1:0]   rsp_col_index,
   output logic [cft_pkg::LEN_BITS-1:0]   rsp_field_len,
   output logic [1:0]                     rsp_error_code,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cft_pkg::LEN_BITS-1:0]   csr_max_field_len
);
   import cft_pkg::*;

   logic [LEN_BITS-1:0] max_len_ff;
   logic                accept;
   logic                can_load;
   logic                has_result;
   rsp_type             result;
   rsp_type             rsp_data;

   // Configuration register, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= LEN_BITS'(4095);
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_field_len;
      end
   end

   // A beat is taken whenever the result register can accept its outcome.
   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   cft_parse_fsm u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_kind       (req_kind),
      .in_byte       (req_data_byte),
      .max_field_len (max_len_ff),
      .has_result    (has_result),
      .result        (result)
   );

   cft_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && has_result),
      .load_data (result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .can_load  (can_load)
   );

   // Result fields onto their ports.
   assign rsp_event_res  = rsp_data.evt;
   assign rsp_out_byte   = rsp_data.out_byte;
   assign rsp_row_index  = rsp_data.row_index;
   assign rsp_col_index  = rsp_data.col_index;
   assign rsp_field_len  = rsp_data.field_len;
   assign rsp_error_code = rsp_data.error_code;

endmodule

// ===== bench/tokenizer_checker.sv =====
// Result checker for the CSV field tokenizer: watches the three channels and predicts each result.
// Depends on cft_pkg for the states, event codes, error codes, characters and the result struct.
`timescale 1ns / 100ps

module tokenizer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_kind,
   input  logic [cft_pkg::BYTE_BITS-1:0]  req_data_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_event_res,
   input  logic [cft_pkg::BYTE_BITS-1:0]  rsp_out_byte,
   input  logic [cft_pkg::ROW_BITS-1:0]   rsp_row_index,
   input  logic [cft_pkg::COL_BITS-1:0]   rsp_col_index,
   input  logic [cft_pkg::LEN_BITS-1:0]   rsp_field_len,
   input  logic [1:0]                     rsp_error_code,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [cft_pkg::LEN_BITS-1:0]   csr_max_field_len,
   output int                             tokens_outstanding,
   output int                             tokens_seen,
   output int                             mismatch_count
);
   import cft_pkg::*;

   localparam logic [LEN_BITS-1:0] LIMIT_AT_RESET = 16'd4095;

   // Our own copy of the tokenizer state and its length limit.
   parse_state_type        tok_state = ST_START;
   logic [ROW_BITS-1:0]    row_cnt   = '0;
   logic [COL_BITS-1:0]    col_cnt   = '0;
   logic [LEN_BITS-1:0]    len_cnt   = '0;
   logic [LEN_BITS-1:0]    max_len   = LIMIT_AT_RESET;

   // Results still owed by the block, oldest first.
   rsp_type expected_tokens[$];

   // A result carries the row and column as they stand when it is made.
   function automatic rsp_type snapshot(input event_type ev, input logic [BYTE_BITS-1:0] b,
                                        input logic [LEN_BITS-1:0] n, input err_code_type code);
      rsp_type r;
      r.evt        = ev;
      r.out_byte   = b;
      r.row_index  = row_cnt;
      r.col_index  = col_cnt;
      r.field_len  = n;
      r.error_code = code;
      return r;
   endfunction

   // Every error parks the parser until reset.
   task automatic flag_error(input err_code_type code, output rsp_type r);
      r = snapshot(EV_ERR, '0, '0, code);
      tok_state = ST_ERROR;
   endtask

   // Field end reports the length, then moves to the next column or row.
   // Non-error results carry a zero error code.
   task automatic close_field(input bit row_end, output rsp_type r);
      r = snapshot(row_end ? EV_ROW : EV_FIELD, '0, len_cnt, ERR_LONG);
      len_cnt   = '0;
      tok_state = ST_START;
      if (row_end) begin
         col_cnt = '0;
         row_cnt = row_cnt + ROW_BITS'(1);
      end else if (col_cnt != COL_MAX) begin
         col_cnt = col_cnt + COL_BITS'(1);
      end
   endtask

   // A field character is emitted unless the field is already full.
   task automatic take_char(input logic [BYTE_BITS-1:0] ch, input parse_state_type nxt,
                            output rsp_type r);
      if (len_cnt >= max_len) begin
         flag_error(ERR_LONG, r);
      end else begin
         tok_state = nxt;
         len_cnt   = len_cnt + LEN_BITS'(1);
         r = snapshot(EV_CHAR, ch, '0, ERR_LONG);
      end
   endtask

   // Work out what one accepted input beat yields and queue it.
   task automatic predict_token(input logic kind, input logic [BYTE_BITS-1:0] ch);
      rsp_type r;
      bit      produced;
      produced = 1'b1;
      if (kind == KIND_EOF) begin
         case (tok_state)
            ST_PLAIN, ST_QQUOTE: close_field(1'b0, r);
            ST_QUOTED, ST_CR:    flag_error(ERR_EOF, r);
            default:             produced = 1'b0;
         endcase
      end else begin
         case (tok_state)
            ST_START, ST_QQUOTE, ST_PLAIN: begin
               if (ch == CH_CR) begin
                  tok_state = ST_CR;
                  produced  = 1'b0;
               end else if (ch == CH_LF) begin
                  close_field(1'b1, r);
               end else if (ch == CH_COMMA) begin
                  close_field(1'b0, r);
               end else if (ch == CH_QUOTE && tok_state != ST_QQUOTE) begin
                  // A stray quote opens quoting and is not part of the field.
                  tok_state = ST_QUOTED;
                  produced  = 1'b0;
               end else begin
                  // The second of a doubled quote is kept and quoting resumes.
                  take_char(ch, (ch == CH_QUOTE) ? ST_QUOTED : ST_PLAIN, r);
               end
            end
            ST_QUOTED: begin
               if (ch == CH_QUOTE) begin
                  tok_state = ST_QQUOTE;
                  produced  = 1'b0;
               end else begin
                  take_char(ch, ST_QUOTED, r);
               end
            end
            ST_CR: begin
               if (ch == CH_LF) close_field(1'b1, r);
               else flag_error(ERR_CR, r);
            end
            default: produced = 1'b0;
         endcase
      end
      if (produced) expected_tokens.push_back(r);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   // At each edge the result beat is checked before the new input beat is predicted,
   // since a result accepted now always belongs to an earlier input.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         tok_state = ST_START;
         row_cnt   = '0;
         col_cnt   = '0;
         len_cnt   = '0;
         max_len   = LIMIT_AT_RESET;
         expected_tokens.delete();
      end else begin
         if (csr_valid && csr_ready) max_len = csr_max_field_len;
         if (rsp_valid && !rsp_stall) begin
            tokens_seen = tokens_seen + 1;
            if (expected_tokens.size() == 0) begin
               $error("Unexpected result beat: event %0d, byte 0x%0h, error code %0d",
                      rsp_event_res, rsp_out_byte, rsp_error_code);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_tokens.pop_front();
               compare_field("event_res", want.evt, rsp_event_res);
               compare_field("out_byte", want.out_byte, rsp_out_byte);
               compare_field("row_index", want.row_index, rsp_row_index);
               compare_field("col_index", want.col_index, rsp_col_index);
               compare_field("field_len", want.field_len, rsp_field_len);
               compare_field("error_code", want.error_code, rsp_error_code);
            end
         end
         if (req_valid && !req_stall) predict_token(req_kind, req_data_byte);
      end
      tokens_outstanding = expected_tokens.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the CSV field tokenizer bench: clock, reset, CSV stimulus, result sink and verdict.
// Depends on cft_pkg, csv_field_tokenizer_top and tokenizer_checker.
`timescale 1ns / 100ps

module testbench;
   import cft_pkg::*;

   localparam int HOLD_CYCLES   = 48;
   localparam int SETTLE_CYCLES = 4;
   localparam int RUN_LIMIT_NS  = 2_000_000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [BYTE_BITS-1:0]  req_data_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_event_res;
   logic [BYTE_BITS-1:0]  rsp_out_byte;
   logic [ROW_BITS-1:0]   rsp_row_index;
   logic [COL_BITS-1:0]   rsp_col_index;
   logic [LEN_BITS-1:0]   rsp_field_len;
   logic [1:0]            rsp_error_code;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LEN_BITS-1:0]   csr_max_field_len;

   int tokens_outstanding;
   int tokens_seen;
   int mismatch_count;

   // Idle ranges for each side, changed from phase to phase.
   int send_gap_max = 8;
   int take_gap_max = 8;
   bit long_hold    = 1'b0;

   // Light tracking of the parser, only to keep the stream free of errors.
   parse_state_type lex_state = ST_START;
   int              lex_len   = 0;
   int              len_limit = 4095;
   int              beats_sent = 0;
   int              limits_written = 0;

   csv_field_tokenizer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_row_index     (rsp_row_index),
      .rsp_col_index     (rsp_col_index),
      .rsp_field_len     (rsp_field_len),
      .rsp_error_code    (rsp_error_code),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_field_len (csr_max_field_len)
   );

   tokenizer_checker token_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_row_index      (rsp_row_index),
      .rsp_col_index      (rsp_col_index),
      .rsp_field_len      (rsp_field_len),
      .rsp_error_code     (rsp_error_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_field_len  (csr_max_field_len),
      .tokens_outstanding (tokens_outstanding),
      .tokens_seen        (tokens_seen),
      .mismatch_count     (mismatch_count)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(RUN_LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   // Result sink: stalls a random number of cycles before each beat, and once
   // holds off for a long stretch so that the block backs up into its input.
   initial begin : result_sink
      int gap;
      rsp_stall = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         if (long_hold) begin
            gap       = HOLD_CYCLES;
            long_hold = 1'b0;
         end else begin
            gap = $urandom_range(0, take_gap_max);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock iff rsp_valid);
         @(negedge clock);
      end
   end

   // Whether the current state keeps this byte as a field character.
   function automatic bit stores_char(input logic [BYTE_BITS-1:0] b);
      case (lex_state)
         ST_QUOTED:          return b != CH_QUOTE;
         ST_QQUOTE:          return !(b inside {CH_CR, CH_LF, CH_COMMA});
         ST_START, ST_PLAIN: return !(b inside {CH_CR, CH_LF, CH_COMMA, CH_QUOTE});
         default:            return 1'b0;
      endcase
   endfunction

   task automatic track_beat(input logic k, input logic [BYTE_BITS-1:0] b);
      if (k == KIND_DATA && stores_char(b)) begin
         lex_len++;
         lex_state = (lex_state == ST_QUOTED || b == CH_QUOTE) ? ST_QUOTED : ST_PLAIN;
      end else if (k == KIND_EOF || lex_state == ST_CR || b == CH_LF || b == CH_COMMA) begin
         lex_state = ST_START;
         lex_len   = 0;
      end else if (b == CH_CR) begin
         lex_state = ST_CR;
      end else if (lex_state == ST_QUOTED) begin
         lex_state = ST_QQUOTE;
      end else begin
         lex_state = ST_QUOTED;
      end
   endtask

   // Offer one input beat after a random gap and hold it until it is taken.
   task automatic send_beat(input logic k, input logic [BYTE_BITS-1:0] b);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= k;
      req_data_byte <= b;
      @(posedge clock iff !req_stall);
      @(negedge clock);
      track_beat(k, b);
      beats_sent++;
   endtask

   // Stop offering and wait until every predicted result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (tokens_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_len_limit(input logic [LEN_BITS-1:0] v);
      drain_results();
      csr_valid         <= 1'b1;
      csr_max_field_len <= v;
      @(posedge clock iff csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      len_limit = int'(v);
      limits_written++;
   endtask

   // Random CSV text that never trips an error: a CR is always followed by LF,
   // end of input never comes inside quotes, and a full field is always closed.
   task automatic random_beats(input int n);
      logic                 k;
      logic [BYTE_BITS-1:0] b;
      int                   roll;
      repeat (n) begin
         roll = $urandom_range(0, 99);
         b    = BYTE_BITS'($urandom_range(0, 255));
         k    = KIND_DATA;
         if (lex_state == ST_CR) b = CH_LF;
         else if (roll < 4 && lex_state != ST_QUOTED) k = KIND_EOF;
         else if (roll < 12) b = CH_COMMA;
         else if (roll < 19) b = CH_QUOTE;
         else if (roll < 23) b = CH_LF;
         else if (roll < 27) b = CH_CR;
         if (k == KIND_DATA && lex_len >= len_limit && stores_char(b))
            b = (lex_state == ST_QUOTED) ? CH_QUOTE : CH_COMMA;
         send_beat(k, b);
      end
   endtask

   // End any open quoting and close the row.
   task automatic close_row();
      if (lex_state == ST_QUOTED) send_beat(KIND_DATA, CH_QUOTE);
      send_beat(KIND_DATA, CH_LF);
   endtask

   initial begin : stimulus
      logic [8:0]   opening[$];
      err_code_type fault;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = KIND_DATA;
      req_data_byte     = '0;
      csr_valid         = 1'b0;
      csr_max_field_len = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Hand-written text: a quoted field holding a doubled quote, CR, LF and a comma;
      // byte extremes with a stray quote that opens quoting; an empty row; end of input
      // in the unquoted, start and after-closing-quote states; empty fields.
      opening = '{
         {KIND_DATA, CH_QUOTE}, {KIND_DATA, "a"}, {KIND_DATA, CH_QUOTE},
         {KIND_DATA, CH_QUOTE}, {KIND_DATA, CH_CR}, {KIND_DATA, CH_LF},
         {KIND_DATA, CH_COMMA}, {KIND_DATA, CH_QUOTE}, {KIND_DATA, CH_COMMA},
         {KIND_DATA, 8'h00}, {KIND_DATA, CH_QUOTE}, {KIND_DATA, 8'hFF},
         {KIND_DATA, CH_QUOTE}, {KIND_DATA, "z"}, {KIND_DATA, CH_CR},
         {KIND_DATA, CH_LF}, {KIND_DATA, CH_LF},
         {KIND_DATA, "k"}, {KIND_EOF, 8'h0A}, {KIND_EOF, 8'hFF},
         {KIND_DATA, CH_QUOTE}, {KIND_DATA, CH_QUOTE}, {KIND_EOF, 8'h22},
         {KIND_DATA, CH_COMMA}, {KIND_DATA, CH_LF}
      };
      foreach (opening[i]) send_beat(opening[i][8], opening[i][7:0]);

      // Short limits, so fields often run right up to the edge.
      write_len_limit(16'd3);
      random_beats(100);
      write_len_limit(16'd1);
      send_gap_max = 0;
      random_beats(60);

      // Widest limit; the sink holds off for a long time while the sender keeps
      // offering, then the sender waits for every result before going on.
      write_len_limit(16'hFFFF);
      send_gap_max = 0;
      take_gap_max = 8;
      long_hold    = 1'b1;
      random_beats(60);
      drain_results();
      send_gap_max = 8;
      random_beats(60);

      write_len_limit(16'd7);
      send_gap_max = 8;
      random_beats(120);

      // Finish on one error; after it the parser must stay silent.
      take_gap_max = 8;
      close_row();
      fault = err_code_type'($urandom_range(0, 2));
      case (fault)
         ERR_LONG: begin
            write_len_limit('0);
            send_beat(KIND_DATA, "a");
         end
         ERR_CR: begin
            send_beat(KIND_DATA, CH_CR);
            send_beat(KIND_DATA, "x");
         end
         default: begin
            send_beat(KIND_DATA, ($urandom_range(0, 1) != 0) ? CH_QUOTE : CH_CR);
            send_beat(KIND_EOF, BYTE_BITS'($urandom_range(0, 255)));
         end
      endcase
      repeat (8) send_beat(1'($urandom_range(0, 1)), BYTE_BITS'($urandom_range(0, 255)));
      drain_results();

      $display("Checked %0d result beats from %0d input beats over %0d length limits,",
               tokens_seen, beats_sent, limits_written + 1);
      $display("including a long result hold-off and a full drain, ending on a %s fault.",
               fault.name());
      if (mismatch_count == 0 && tokens_outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
